>>> hw/rtl/i2cbm_pkg.sv
// Shared types and constants for the I2C byte-level master engine.
// No dependencies; imported by the front queue, the bit engine and the top level.
package i2cbm_pkg;

    localparam int HALF_W = 10;
    localparam logic [HALF_W-1:0] HALF_RESET = 10'd10;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // one classified tick as it travels from the front queue to the engine
    typedef struct packed {
        logic       cmd_valid;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       nack;
    } result_t;

    typedef struct packed {
        logic  valid;
        tick_t tick;
    } tick_chan_t;

endpackage

>>> hw/rtl/i2cbm_front.sv
// Front end: accepts input ticks, decodes the command code and queues them.
// Depends on i2cbm_pkg.
module i2cbm_front #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd_valid,
    input  logic [1:0]             req_type,
    input  logic [7:0]             tx_byte,
    input  logic                   send_ack,
    input  logic                   sda_in,
    output i2cbm_pkg::tick_chan_t  q_out,
    input  logic                   q_ready
);
    import i2cbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tick_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    tick_t             tick_in;
    logic              push, pop;

    // every 2-bit code is a valid command
    always_comb
    begin
        tick_in.cmd_valid = cmd_valid;
        tick_in.cmd       = cmd_t'(req_type);
        tick_in.tx_byte   = tx_byte;
        tick_in.send_ack  = send_ack;
        tick_in.sda_in    = sda_in;
    end

    assign in_ready   = (count_reg != FULL_CNT);
    assign push       = in_valid && in_ready;
    assign q_out.valid = (count_reg != '0);
    assign q_out.tick  = entry_reg[rd_ptr_reg];
    assign pop        = q_out.valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= tick_in;
    end

endmodule

>>> hw/rtl/i2cbm_engine.sv
// Back end: bit-level I2C sequencer, one tick per transfer, with an output register.
// Depends on i2cbm_pkg.
module i2cbm_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  i2cbm_pkg::tick_chan_t           q_in,
    output logic                            q_ready,
    input  logic [i2cbm_pkg::HALF_W-1:0]    half_period,
    output logic                            out_valid,
    input  logic                            out_ready,
    output i2cbm_pkg::result_t              res
);
    import i2cbm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A,
        PH_W_DATA, PH_W_HIGH, PH_W_LOW,
        PH_R_HIGH, PH_R_LOW, PH_RA_SET, PH_RA_HIGH, PH_RA_LOW
    } phase_t;

    phase_t            phase_reg, phase_next, enter_phase;
    logic [HALF_W-1:0] delay_reg, delay_next, hold;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic              ack_reg, ack_next;
    logic [7:0]        rx_reg, rx_next;
    logic              nack_reg, nack_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;
    logic              take, do_enter, done;
    tick_t             tk;

    assign q_ready   = !out_valid_reg || out_ready;
    assign take      = q_in.valid && q_ready;
    assign tk        = q_in.tick;
    assign hold      = (half_period == '0) ? HALF_W'(1) : half_period;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        delay_next  = delay_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        ack_next    = ack_reg;
        rx_next     = rx_reg;
        nack_next   = nack_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        enter_phase = PH_IDLE;
        do_enter    = 1'b0;
        done        = 1'b0;

        if (take)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (tk.cmd_valid)
                begin
                    bit_next = '0;
                    do_enter = 1'b1;
                    case (tk.cmd)
                        CMD_START: enter_phase = PH_ST_A;
                        CMD_STOP:  enter_phase = PH_SP_A;
                        CMD_WRITE:
                        begin
                            shift_next  = tk.tx_byte;
                            enter_phase = PH_W_DATA;
                        end
                        default:
                        begin
                            shift_next  = '0;
                            ack_next    = tk.send_ack;
                            enter_phase = PH_R_HIGH;
                        end
                    endcase
                end
            end
            else
            begin
                if (delay_next != '0)
                    delay_next = delay_next - 1'b1;
                if (delay_next == '0)
                begin
                    do_enter = 1'b1;
                    case (phase_reg)
                        PH_ST_A:   enter_phase = PH_ST_B;
                        PH_ST_B:   enter_phase = PH_ST_C;
                        PH_ST_C:
                        begin
                            do_enter = 1'b0;
                            done     = 1'b1;
                        end
                        PH_SP_A:
                        begin
                            do_enter = 1'b0;
                            sda_next = 1'b1;
                            done     = 1'b1;
                        end
                        PH_W_DATA: enter_phase = PH_W_HIGH;
                        PH_W_HIGH:
                        begin
                            if (bit_reg == 4'd8)
                                nack_next = tk.sda_in;  // acknowledge sample
                            enter_phase = PH_W_LOW;
                        end
                        PH_W_LOW:
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 1'b1;
                            if (bit_next > 4'd8)
                            begin
                                do_enter = 1'b0;
                                done     = 1'b1;
                            end
                            else
                                enter_phase = PH_W_DATA;
                        end
                        PH_R_HIGH:
                        begin
                            shift_next  = {shift_reg[6:0], tk.sda_in};
                            enter_phase = PH_R_LOW;
                        end
                        PH_R_LOW:
                        begin
                            bit_next    = bit_reg + 1'b1;
                            enter_phase = (bit_next >= 4'd8) ? PH_RA_SET : PH_R_HIGH;
                        end
                        PH_RA_SET:  enter_phase = PH_RA_HIGH;
                        PH_RA_HIGH: enter_phase = PH_RA_LOW;
                        PH_RA_LOW:
                        begin
                            do_enter = 1'b0;
                            sda_next = 1'b1;
                            rx_next  = shift_reg;
                            done     = 1'b1;
                        end
                        default:
                        begin
                            do_enter   = 1'b0;
                            phase_next = PH_IDLE;
                            delay_next = '0;
                        end
                    endcase
                end
            end

            if (do_enter)
            begin
                phase_next = enter_phase;
                delay_next = hold;
                case (enter_phase)
                    PH_ST_A:
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    PH_ST_B:   sda_next = 1'b0;
                    PH_ST_C:   scl_next = 1'b0;
                    PH_SP_A:
                    begin
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    // ninth bit releases SDA for the acknowledge
                    PH_W_DATA: sda_next = (bit_next < 4'd8) ? shift_next[7] : 1'b1;
                    PH_W_HIGH: scl_next = 1'b1;
                    PH_W_LOW:
                    begin
                        scl_next = 1'b0;
                        if (bit_next == 4'd7)
                            sda_next = 1'b1;
                    end
                    PH_R_HIGH:
                    begin
                        if (bit_next == '0)
                            sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    PH_R_LOW:   scl_next = 1'b0;
                    PH_RA_SET:  sda_next = !ack_next;
                    PH_RA_HIGH: scl_next = 1'b1;
                    PH_RA_LOW:  scl_next = 1'b0;
                    default:
                    begin
                        phase_next = PH_IDLE;
                        delay_next = '0;
                    end
                endcase
            end

            if (done)
            begin
                phase_next = PH_IDLE;
                delay_next = '0;
            end
        end
    end

    always_comb
    begin
        res_next.scl     = scl_next;
        res_next.sda     = sda_next;
        res_next.busy    = (phase_next != PH_IDLE);
        res_next.done    = done;
        res_next.rx_byte = rx_next;
        res_next.nack    = nack_next;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            delay_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            ack_reg       <= 1'b0;
            rx_reg        <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            delay_reg     <= delay_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            ack_reg       <= ack_next;
            rx_reg        <= rx_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            out_valid_reg <= out_valid_next;
            if (take)
                res_reg <= res_next;
        end
    end

endmodule

>>> hw/rtl/i2c_bitbang_master_engine.sv
// I2C byte-level master engine: tick queue in front, bit sequencer and output register behind.
// A tick accepted into the front queue is registered by the engine once the engine is ready,
// and its result transfers from that output register when out_ready is high.
// Throughput: one tick per cycle while out_ready holds; the engine consumes one queued tick per clock.
// Reset: engine idle, its SCL and SDA released, output register, flags and received byte cleared,
// half period 10 ticks. Config port is always ready.
// Depends on i2cbm_pkg, i2cbm_front and i2cbm_engine.
module i2c_bitbang_master_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd_valid,
    input  logic [1:0]                   req_type,
    input  logic [7:0]                   tx_byte,
    input  logic                         send_ack,
    input  logic                         sda_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         scl_out,
    output logic                         sda_out,
    output logic                         busy_res,
    output logic                         done_res,
    output logic [7:0]                   rx_byte,
    output logic                         nack_seen,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [i2cbm_pkg::HALF_W-1:0] cfg_data
);
    import i2cbm_pkg::*;

    tick_chan_t        q_chan;
    logic              q_ready;
    result_t           res;
    logic [HALF_W-1:0] half_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= HALF_RESET;
        else if (cfg_valid && cfg_ready)
            half_reg <= cfg_data;
    end

    i2cbm_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd_valid (cmd_valid),
        .req_type  (req_type),
        .tx_byte   (tx_byte),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .q_out     (q_chan),
        .q_ready   (q_ready)
    );

    i2cbm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_in        (q_chan),
        .q_ready     (q_ready),
        .half_period (half_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res         (res)
    );

    assign scl_out   = res.scl;
    assign sda_out   = res.sda;
    assign busy_res  = res.busy;
    assign done_res  = res.done;
    assign rx_byte   = res.rx_byte;
    assign nack_seen = res.nack;

endmodule

>>> test/tb_top.sv
// Self-checking bench for the I2C byte-level master engine: a directed command table,
// then random bus transactions under several half-period settings, all against a tick model.
// Depends on i2cbm_pkg and i2c_bitbang_master_engine.
module tb_top;
    import i2cbm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_ROWS = 14;
    localparam int FAST_ROW = 2;
    localparam int TICK_GOAL = 120;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START_A, ST_START_B, ST_START_C, ST_STOP_A,
        ST_WR_DATA, ST_WR_HIGH, ST_WR_LOW, ST_RD_HIGH, ST_RD_LOW,
        ST_ACK_SET, ST_ACK_HIGH, ST_ACK_LOW
    } bus_state_t;

    typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;
    typedef enum logic {ROW_IDLE, ROW_CMD} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        cmd_t       cmd;
        logic [7:0] tx;
        logic       ack;
        sda_mode_t  sda_mode;
        logic       spam;
        logic       typed;
        logic [7:0] want_rx;
        logic       want_nack;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              cmd_valid = 1'b0;
    cmd_t              req_type = CMD_START;
    logic [7:0]        tx_byte = 8'h00;
    logic              send_ack = 1'b0;
    logic              sda_in = 1'b1;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [7:0]        rx_byte;
    logic              nack_seen;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [HALF_W-1:0] cfg_data = '0;

    // tick model state
    bus_state_t        eng_state;
    logic [3:0]        eng_bit;
    logic [HALF_W-1:0] eng_wait;
    logic [7:0]        eng_shift;
    logic              eng_ack;
    logic [7:0]        eng_rx;
    logic              eng_nack;
    logic              eng_scl;
    logic              eng_sda;
    logic [HALF_W-1:0] eng_half;

    result_t pending_results[$];
    int      err_cnt = 0;
    int      cycles = 0;
    int      tick_cnt = 0;
    int      stall_left = 0;
    bit      allow_idle = 1'b1;
    row_t    dir_rows[NUM_ROWS];

    i2c_bitbang_master_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd_valid (cmd_valid),
        .req_type  (req_type),
        .tx_byte   (tx_byte),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scl_out   (scl_out),
        .sda_out   (sda_out),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rx_byte   (rx_byte),
        .nack_seen (nack_seen),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void enter_phase(input bus_state_t nxt);
        eng_state = nxt;
        eng_wait = (eng_half == '0) ? HALF_W'(1) : eng_half;
        case (nxt)
            ST_START_A:
            begin
                eng_sda = 1'b1;
                eng_scl = 1'b1;
            end
            ST_START_B: eng_sda = 1'b0;
            ST_START_C: eng_scl = 1'b0;
            ST_STOP_A:
            begin
                eng_sda = 1'b0;
                eng_scl = 1'b1;
            end
            // ninth bit releases SDA for the acknowledge
            ST_WR_DATA: eng_sda = (eng_bit < 4'd8) ? eng_shift[7] : 1'b1;
            ST_WR_HIGH: eng_scl = 1'b1;
            ST_WR_LOW:
            begin
                eng_scl = 1'b0;
                if (eng_bit == 4'd7)
                    eng_sda = 1'b1;
            end
            ST_RD_HIGH:
            begin
                if (eng_bit == 4'd0)
                    eng_sda = 1'b1;
                eng_scl = 1'b1;
            end
            ST_RD_LOW: eng_scl = 1'b0;
            ST_ACK_SET: eng_sda = ~eng_ack;
            ST_ACK_HIGH: eng_scl = 1'b1;
            ST_ACK_LOW: eng_scl = 1'b0;
            default:
            begin
                eng_state = ST_IDLE;
                eng_wait = '0;
            end
        endcase
    endfunction

    // end of the current phase; returns 1 when the command completes
    function bit close_phase(input logic sda);
        bit fin;
        fin = 1'b0;
        case (eng_state)
            ST_START_A: enter_phase(ST_START_B);
            ST_START_B: enter_phase(ST_START_C);
            ST_START_C: fin = 1'b1;
            ST_STOP_A:
            begin
                eng_sda = 1'b1;
                fin = 1'b1;
            end
            ST_WR_DATA: enter_phase(ST_WR_HIGH);
            ST_WR_HIGH:
            begin
                if (eng_bit == 4'd8)
                    eng_nack = sda;
                enter_phase(ST_WR_LOW);
            end
            ST_WR_LOW:
            begin
                eng_shift = eng_shift << 1;
                eng_bit = eng_bit + 4'd1;
                if (eng_bit > 4'd8)
                    fin = 1'b1;
                else
                    enter_phase(ST_WR_DATA);
            end
            ST_RD_HIGH:
            begin
                eng_shift = {eng_shift[6:0], sda};
                enter_phase(ST_RD_LOW);
            end
            ST_RD_LOW:
            begin
                eng_bit = eng_bit + 4'd1;
                if (eng_bit >= 4'd8)
                    enter_phase(ST_ACK_SET);
                else
                    enter_phase(ST_RD_HIGH);
            end
            ST_ACK_SET: enter_phase(ST_ACK_HIGH);
            ST_ACK_HIGH: enter_phase(ST_ACK_LOW);
            ST_ACK_LOW:
            begin
                eng_sda = 1'b1;
                eng_rx = eng_shift;
                fin = 1'b1;
            end
            default: fin = 1'b0;
        endcase
        return fin;
    endfunction

    function result_t predict_bus_tick(input logic cv, input cmd_t req, input logic [7:0] tx,
                                       input logic ack, input logic sda);
        result_t r;
        logic    done;
        done = 1'b0;
        if (eng_state == ST_IDLE)
        begin
            if (cv)
            begin
                eng_bit = '0;
                case (req)
                    CMD_START: enter_phase(ST_START_A);
                    CMD_STOP: enter_phase(ST_STOP_A);
                    CMD_WRITE:
                    begin
                        eng_shift = tx;
                        enter_phase(ST_WR_DATA);
                    end
                    default:
                    begin
                        eng_shift = '0;
                        eng_ack = ack;
                        enter_phase(ST_RD_HIGH);
                    end
                endcase
            end
        end
        else
        begin
            if (eng_wait > 0)
                eng_wait = eng_wait - 1'b1;
            if (eng_wait == 0)
            begin
                if (close_phase(sda))
                begin
                    eng_state = ST_IDLE;
                    eng_wait = '0;
                    done = 1'b1;
                end
            end
        end
        r.scl = eng_scl;
        r.sda = eng_sda;
        r.busy = (eng_state != ST_IDLE);
        r.done = done;
        r.rx_byte = eng_rx;
        r.nack = eng_nack;
        return r;
    endfunction

    function row_t mk_step(input row_kind_t kind, input cmd_t cmd, input logic [7:0] tx,
                           input logic ack, input sda_mode_t mode, input logic spam,
                           input logic typed, input logic [7:0] want_rx,
                           input logic want_nack);
        row_t s;
        s.kind = kind;
        s.cmd = cmd;
        s.tx = tx;
        s.ack = ack;
        s.sda_mode = mode;
        s.spam = spam;
        s.typed = typed;
        s.want_rx = want_rx;
        s.want_nack = want_nack;
        return s;
    endfunction

    function logic pick_sda(input sda_mode_t mode);
        if (mode == SDA_RAND)
            return logic'($urandom_range(0, 1));
        return (mode == SDA_HIGH);
    endfunction

    function void report(input string what, input int unsigned want, input int unsigned got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // one tick transfer; the expectation is queued at the accepting edge
    task automatic send_tick(input logic cv, input cmd_t req, input logic [7:0] tx,
                             input logic ack, input logic sda);
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_valid <= cv;
        req_type <= req;
        tx_byte <= tx;
        send_ack <= ack;
        sda_in <= sda;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_bus_tick(cv, req, tx, ack, sda));
        tick_cnt++;
    endtask

    // offer a command, then tick until the model says it is done
    task automatic run_command(input cmd_t req, input logic [7:0] tx, input logic ack,
                               input sda_mode_t mode, input logic spam);
        send_tick(1'b1, req, tx, ack, pick_sda(mode));
        while (eng_state != ST_IDLE)
            send_tick(spam && ($urandom_range(0, 1) == 1), cmd_t'($urandom_range(0, 3)),
                      8'($urandom), logic'($urandom_range(0, 1)), pick_sda(mode));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_half(input logic [HALF_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        eng_half = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_transaction();
        int   pick;
        logic spam;
        pick = $urandom_range(0, 9);
        spam = ($urandom_range(0, 4) == 0);
        if (pick < 7)
        begin
            run_command(CMD_START, 8'($urandom), 1'b0, SDA_RAND, spam);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 1) == 1)
                    run_command(CMD_WRITE, 8'($urandom), logic'($urandom_range(0, 1)),
                                SDA_RAND, spam);
                else
                    run_command(CMD_READ, 8'($urandom), logic'($urandom_range(0, 1)),
                                SDA_RAND, spam);
            end
            run_command(CMD_STOP, 8'($urandom), 1'b0, SDA_RAND, spam);
        end
        else if (pick < 9)
        begin
            run_command(cmd_t'($urandom_range(0, 3)), 8'($urandom),
                        logic'($urandom_range(0, 1)), SDA_RAND, spam);
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                send_tick(1'b0, cmd_t'($urandom_range(0, 3)), 8'($urandom),
                          logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
        end
    endtask

    always @(posedge clk)
    begin : rx_side
        result_t want;
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {scl_out, sda_out, busy_res, done_res, rx_byte, nack_seen};
            if (pending_results.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.scl !== want.scl)
                    report("scl_out", want.scl, got.scl);
                if (got.sda !== want.sda)
                    report("sda_out", want.sda, got.sda);
                if (got.busy !== want.busy)
                    report("busy_res", want.busy, got.busy);
                if (got.done !== want.done)
                    report("done_res", want.done, got.done);
                if (got.rx_byte !== want.rx_byte)
                    report("rx_byte", want.rx_byte, got.rx_byte);
                if (got.nack !== want.nack)
                    report("nack_seen", want.nack, got.nack);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 17) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int half_plan[7];
        int goal;
        eng_state = ST_IDLE;
        eng_bit = '0;
        eng_wait = '0;
        eng_shift = '0;
        eng_ack = 1'b0;
        eng_rx = '0;
        eng_nack = 1'b0;
        eng_scl = 1'b1;
        eng_sda = 1'b1;
        eng_half = HALF_RESET;

        dir_rows[0]  = mk_step(ROW_IDLE, CMD_START, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1, 8'h00, 1'b0);
        dir_rows[1]  = mk_step(ROW_CMD, CMD_START, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1, 8'h00, 1'b0);
        dir_rows[2]  = mk_step(ROW_CMD, CMD_WRITE, 8'hA5, 1'b0, SDA_LOW, 1'b0, 1'b1, 8'h00, 1'b0);
        dir_rows[3]  = mk_step(ROW_CMD, CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH, 1'b0, 1'b1, 8'h00, 1'b1);
        dir_rows[4]  = mk_step(ROW_CMD, CMD_WRITE, 8'h00, 1'b1, SDA_LOW, 1'b0, 1'b1, 8'h00, 1'b0);
        dir_rows[5]  = mk_step(ROW_CMD, CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0, 1'b1, 8'hFF, 1'b0);
        dir_rows[6]  = mk_step(ROW_CMD, CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0, 1'b1, 8'h00, 1'b0);
        dir_rows[7]  = mk_step(ROW_CMD, CMD_STOP, 8'h00, 1'b0, SDA_LOW, 1'b0, 1'b1, 8'h00, 1'b0);
        // commands offered while busy must be dropped, including on the completion tick
        dir_rows[8]  = mk_step(ROW_CMD, CMD_START, 8'h3C, 1'b0, SDA_RAND, 1'b1, 1'b0, 8'h00, 1'b0);
        dir_rows[9]  = mk_step(ROW_CMD, CMD_WRITE, 8'h80, 1'b0, SDA_RAND, 1'b1, 1'b0, 8'h00, 1'b0);
        dir_rows[10] = mk_step(ROW_CMD, CMD_READ, 8'h5A, 1'b1, SDA_RAND, 1'b1, 1'b0, 8'h00, 1'b0);
        dir_rows[11] = mk_step(ROW_CMD, CMD_WRITE, 8'h01, 1'b0, SDA_HIGH, 1'b0, 1'b0, 8'h00, 1'b0);
        dir_rows[12] = mk_step(ROW_CMD, CMD_STOP, 8'hC3, 1'b1, SDA_RAND, 1'b1, 1'b0, 8'h00, 1'b0);
        dir_rows[13] = mk_step(ROW_IDLE, CMD_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0, 1'b0, 8'h00, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run at the reset half period, the rest at the shortest one
        foreach (dir_rows[i])
        begin
            if (i == FAST_ROW)
                write_half(HALF_W'(1));
            if (dir_rows[i].kind == ROW_IDLE)
                send_tick(1'b0, dir_rows[i].cmd, dir_rows[i].tx, dir_rows[i].ack,
                          pick_sda(dir_rows[i].sda_mode));
            else
                run_command(dir_rows[i].cmd, dir_rows[i].tx, dir_rows[i].ack,
                            dir_rows[i].sda_mode, dir_rows[i].spam);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].kind == ROW_IDLE)
                begin
                    pending_results[$].scl = 1'b1;
                    pending_results[$].sda = 1'b1;
                    pending_results[$].busy = 1'b0;
                    pending_results[$].done = 1'b0;
                end
                else
                begin
                    pending_results[$].busy = 1'b0;
                    pending_results[$].done = 1'b1;
                end
                pending_results[$].rx_byte = dir_rows[i].want_rx;
                pending_results[$].nack = dir_rows[i].want_nack;
            end
        end

        half_plan = '{1, 0, 2, 3, $urandom_range(4, 9), 2, 1};
        foreach (half_plan[k])
        begin
            write_half(HALF_W'(half_plan[k]));
            if (k == $size(half_plan) - 1)
                allow_idle = 1'b0;
            goal = tick_cnt + TICK_GOAL;
            while (tick_cnt < goal)
            begin
                if (k != $size(half_plan) - 1)
                    allow_idle = ($urandom_range(0, 3) != 0);
                random_transaction();
            end
        end

        wait_drained();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
